// ----- sv/circle_outline_span_generator_macros.svh -----
// Assertion macros for the circle outline span generator.
// Included by cosg_datapath, which carries the concurrent checks; needs clk and rst_n in scope.
`ifndef CIRCLE_OUTLINE_SPAN_GENERATOR_MACROS_SVH
`define CIRCLE_OUTLINE_SPAN_GENERATOR_MACROS_SVH

// Same-cycle implication, checked only out of reset
`define COSG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset
`define COSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/cosg_pkg.sv -----
// Shared types and constants of the circle outline span generator.
// No dependencies; used by all modules of the block.
package cosg_pkg;

  // Field widths
  localparam int COORD_W  = 12;
  localparam int RADIUS_W = 5;
  localparam int COLOR_W  = 8;
  localparam int ALPHA_W  = 8;
  localparam int SPAN_W   = 14;
  localparam int WIDTH_W  = 6;
  localparam int PSIZE_W  = 9;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 2;

  // Stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  // Square root unit: operand width and first trial bit (power of four)
  localparam int SQRT_W = 10;
  localparam logic [SQRT_W-1:0] SQRT_FIRST_BIT = 10'd256;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_SIZE = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic       capture;     // latch a new request
    logic       sqrt_start;  // start half-width of the next row
    logic       row_next;    // advance to the next row
    logic       emit;        // load one span into the output register
    logic [1:0] slot;        // span position within the row
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic first_row;
    logic last_row;
    logic sqrt_done;
    logic out_free;
  } status_t;

endpackage

// ----- sv/cosg_isqrt.sv -----
// Iterative integer square root, one root bit per cycle.
// Depends on cosg_pkg.
module cosg_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cosg_pkg::SQRT_W-1:0] operand,
  output logic                        done,
  output logic [cosg_pkg::RADIUS_W-1:0] root
);

  logic [cosg_pkg::SQRT_W-1:0] rem_r, rem_nxt;
  logic [cosg_pkg::SQRT_W-1:0] root_r, root_nxt;
  logic [cosg_pkg::SQRT_W-1:0] bit_r, bit_nxt;
  logic [cosg_pkg::SQRT_W-1:0] trial;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;

  // One restoring step of the digit-by-digit root
  always_comb begin
    trial    = root_r + bit_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = operand;
      root_nxt = '0;
      bit_nxt  = cosg_pkg::SQRT_FIRST_BIT;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt  = rem_r - trial;
        root_nxt = (root_r >> 1) + bit_r;
      end else begin
        root_nxt = root_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r == {{(cosg_pkg::SQRT_W-1){1'b0}}, 1'b1}) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rem_r  <= '0;
      root_r <= '0;
      bit_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      bit_r  <= bit_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r[cosg_pkg::RADIUS_W-1:0];

endmodule

// ----- sv/cosg_datapath.sv -----
// Datapath: configuration registers, latched request, row values and output register.
// Depends on cosg_pkg, cosg_isqrt and the assertion macro header.
`include "circle_outline_span_generator_macros.svh"

module cosg_datapath #(
  parameter int MAX_RADIUS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cosg_pkg::cmd_t                      cmd,
  output cosg_pkg::status_t                   status,
  input  logic [cosg_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                cfg_we,
  input  logic [cosg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cosg_pkg::CFG_W-1:0]          cfg_wdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [cosg_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tlast
);

  localparam int CW = cosg_pkg::COORD_W;
  localparam int RW = cosg_pkg::RADIUS_W;
  localparam int SW = cosg_pkg::SPAN_W;

  // Configuration
  logic [CW-1:0]                 off_x_r, off_y_r;
  logic [cosg_pkg::PSIZE_W-1:0]  psize_r;

  // Latched request
  logic [CW-1:0]                 cx_r, cy_r;
  logic [RW-1:0]                 rad_r;
  logic [2*RW-1:0]               rsq_r;
  logic [cosg_pkg::COLOR_W-1:0]  pidx_r;
  logic                          pempty_r;
  logic [cosg_pkg::ALPHA_W-1:0]  alpha_r;

  // Row state
  logic [RW-1:0]                 row_r, dx_r, dxn_r;

  // Output register
  logic                          out_valid_r;
  logic [SW-1:0]                 span_x_r, span_y_r;
  logic [cosg_pkg::WIDTH_W-1:0]  span_width_r;
  logic [cosg_pkg::COLOR_W-1:0]  span_pidx_r;
  logic                          span_pempty_r;
  logic [cosg_pkg::ALPHA_W-1:0]  span_alpha_r;
  logic                          span_last_r;

  // Request fields
  logic [CW-1:0]                 in_cx, in_cy;
  logic [RW-1:0]                 in_rad, rad_sat;
  logic [cosg_pkg::COLOR_W-1:0]  in_color, pidx_calc;
  logic [cosg_pkg::ALPHA_W-1:0]  in_alpha;
  logic [cosg_pkg::PSIZE_W-1:0]  psize_m1;

  // Row arithmetic
  logic [RW-1:0]                 row_p1, thick;
  logic [2*RW-1:0]               next_sq;
  logic [cosg_pkg::SQRT_W-1:0]   sqrt_work;
  logic                          sq_done;
  logic [RW-1:0]                 sq_root;
  logic                          first_row, last_row, out_free;
  logic [SW-1:0]                 cx14, cy14, offx14, offy14, dx14, row14, thick14;
  logic [SW-1:0]                 left_x, right_x, top_y, bot_y, sel_x, sel_y;
  logic [cosg_pkg::WIDTH_W-1:0]  sel_width;

  assign in_cx    = in_tdata[11:0];
  assign in_cy    = in_tdata[23:12];
  assign in_rad   = in_tdata[28:24];
  assign in_color = in_tdata[36:29];
  assign in_alpha = in_tdata[44:37];

  // Saturate the radius and clamp the color index below the palette size
  assign rad_sat  = (in_rad > RW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : in_rad;
  assign psize_m1 = psize_r - 9'd1;
  assign pidx_calc = ({1'b0, in_color} < psize_m1) ? in_color : psize_m1[7:0];

  // Hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0;
      off_y_r <= '0;
      psize_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cosg_pkg::CFG_OFFSET_X:     off_x_r <= cfg_wdata[CW-1:0];
        cosg_pkg::CFG_OFFSET_Y:     off_y_r <= cfg_wdata[CW-1:0];
        cosg_pkg::CFG_PALETTE_SIZE: psize_r <= cfg_wdata[cosg_pkg::PSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Operand of the next row's half width: r*r - (dy+1)^2
  assign row_p1    = row_r + 5'd1;
  assign next_sq   = (2*RW)'(row_p1) * (2*RW)'(row_p1);
  assign sqrt_work = rsq_r - next_sq;

  cosg_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.sqrt_start),
    .operand (sqrt_work),
    .done    (sq_done),
    .root    (sq_root)
  );

  // Latch request, advance rows, capture root
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      dx_r  <= '0;
      dxn_r <= '0;
      rad_r <= '0;
    end else begin
      if (cmd.capture) begin
        row_r <= '0;
        dx_r  <= rad_sat;
        rad_r <= rad_sat;
      end else if (cmd.row_next) begin
        row_r <= row_p1;
        dx_r  <= dxn_r;
      end
      if (sq_done) begin
        dxn_r <= sq_root;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cx_r     <= in_cx;
      cy_r     <= in_cy;
      rsq_r    <= (2*RW)'(rad_sat) * (2*RW)'(rad_sat);
      pidx_r   <= (psize_r == '0) ? '0 : pidx_calc;
      pempty_r <= (psize_r == '0);
      alpha_r  <= in_alpha;
    end
  end

  assign first_row = (row_r == '0);
  assign last_row  = (row_r == rad_r);
  assign thick     = (dx_r > dxn_r + 5'd1) ? (dx_r - dxn_r) : 5'd1;

  // Span geometry in 14-bit two's complement
  assign cx14    = {{(SW-CW){cx_r[CW-1]}}, cx_r};
  assign cy14    = {{(SW-CW){cy_r[CW-1]}}, cy_r};
  assign offx14  = {{(SW-CW){off_x_r[CW-1]}}, off_x_r};
  assign offy14  = {{(SW-CW){off_y_r[CW-1]}}, off_y_r};
  assign dx14    = SW'(dx_r);
  assign row14   = SW'(row_r);
  assign thick14 = SW'(thick);
  assign left_x  = cx14 - dx14 + offx14;
  assign right_x = cx14 + dx14 - thick14 + offx14;
  assign top_y   = cy14 - row14 + offy14;
  assign bot_y   = cy14 + row14 + offy14;

  // Pick the span for this slot
  always_comb begin
    if (last_row) begin
      sel_x     = left_x;
      sel_y     = cmd.slot[0] ? bot_y : top_y;
      sel_width = {dx_r, 1'b0};
    end else begin
      sel_x     = cmd.slot[0] ? right_x : left_x;
      sel_y     = cmd.slot[1] ? bot_y : top_y;
      sel_width = cosg_pkg::WIDTH_W'(thick);
    end
  end

  assign out_free = !out_valid_r || out_tready;

  // Load the output register, drop it after the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      span_x_r      <= sel_x;
      span_y_r      <= sel_y;
      span_width_r  <= sel_width;
      span_pidx_r   <= pidx_r;
      span_pempty_r <= pempty_r;
      span_alpha_r  <= alpha_r;
      span_last_r   <= last_row && cmd.slot[0];
    end
  end

  assign status.first_row = first_row;
  assign status.last_row  = last_row;
  assign status.sqrt_done = sq_done;
  assign status.out_free  = out_free;

  assign out_tvalid = out_valid_r;
  assign out_tlast  = span_last_r;
  assign out_tdata  = {5'd0, span_alpha_r, span_pempty_r, span_pidx_r, span_width_r,
                       span_y_r, span_x_r};

  `COSG_ASSERT_NOW(a_emit_into_free, cmd.emit, !out_valid_r || out_tready, "span over pending")
  `COSG_ASSERT_NOW(a_root_not_wider, sq_done, sq_root <= dx_r, "next row wider than this row")
  `COSG_ASSERT_NOW(a_row_in_range, 1'b1, row_r <= rad_r, "row index beyond radius")

endmodule

// ----- sv/cosg_ctrl.sv -----
// Controller: walks the rows of a circle and the span slots of each row.
// Depends on cosg_pkg.
module cosg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  cosg_pkg::status_t status,
  output cosg_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {ST_IDLE, ST_ROW, ST_SQRT, ST_EMIT} state_t;

  state_t     state_r, state_nxt;
  logic [1:0] slot_r, slot_nxt;
  logic [1:0] last_slot;

  // Edge rows carry two spans, middle rows four
  assign last_slot = (status.first_row || status.last_row) ? 2'd1 : 2'd3;

  always_comb begin
    state_nxt      = state_r;
    slot_nxt       = slot_r;
    cmd.capture    = 1'b0;
    cmd.sqrt_start = 1'b0;
    cmd.row_next   = 1'b0;
    cmd.emit       = 1'b0;
    cmd.slot       = slot_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_ROW;
        end
      end
      ST_ROW: begin
        slot_nxt = 2'd0;
        if (status.last_row) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (status.sqrt_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (slot_r == last_slot) begin
            slot_nxt = 2'd0;
            if (status.last_row) begin
              state_nxt = ST_IDLE;
            end else begin
              cmd.row_next = 1'b1;
              state_nxt    = ST_ROW;
            end
          end else begin
            slot_nxt = slot_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      slot_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

endmodule

// ----- sv/circle_outline_span_generator.sv -----
// Circle outline span generator: turns circle requests into one-pixel-high spans.
// Channels: in_* takes one request per transfer; out_* gives one span per transfer,
// out_tlast marks the final span of a circle. cfg_* writes the column offset (0), the
// row offset (1) and the palette entry count (2); write only while no circle is in flight.
// A circle of radius r > 0 gives 4*r spans, radius 0 gives two spans of width 0;
// radii above MAX_RADIUS saturate.
// Sequence: each row but the last passes through a setup state and the iterative
// square root, then emits its spans in turn, pausing while the receiver stalls; the
// last row goes from its setup state straight to its two spans.
// The single square root unit, one root bit per cycle, sets the row time.
// After a request transfer the first span is loaded once the setup state and, for
// r > 0, the square root have passed.
// A new request is taken once the last span of the previous circle sits in the
// output register; a receiver stall holds the output register and pauses span
// generation. Synchronous active-low reset empties the output register, returns
// the controller to idle and clears the configuration registers to zero.
// Depends on cosg_pkg, cosg_ctrl, cosg_datapath and cosg_isqrt.
module circle_outline_span_generator #(
  parameter int MAX_RADIUS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // center_x[11:0], center_y[23:12], radius[28:24], color_index[36:29], alpha[44:37]
  input  logic [cosg_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // span_x[13:0], span_y[27:14], span_width[33:28], palette_index[41:34],
  // palette_empty[42], span_alpha[50:43]
  output logic [cosg_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [cosg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cosg_pkg::CFG_W-1:0]          cfg_wdata
);

  cosg_pkg::cmd_t    cmd;
  cosg_pkg::status_t status;

  cosg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  cosg_datapath #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
